/* rtl/core/bskv_pkg.sv */
package bskv_pkg;

   // Character codes the tokenizer reacts to
   localparam logic [7:0] NUL_CH   = 8'h00;
   localparam logic [7:0] EQUAL_CH = 8'h3D;
   localparam logic [7:0] QUOTE_CH = 8'h27;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [7:0] TAB_CH   = 8'h09;
   localparam logic [7:0] CR_CH    = 8'h0D;

   // Role codes reported with each byte
   localparam logic [1:0] ROLE_SKIP    = 2'd0;
   localparam logic [1:0] ROLE_NAME    = 2'd1;
   localparam logic [1:0] ROLE_VALUE   = 2'd2;
   localparam logic [1:0] ROLE_IGNORED = 2'd3;

   // Configuration register indexes
   localparam int unsigned CsrIdxW = 8;
   localparam logic [CsrIdxW-1:0] CSR_LOOKUP_ENABLE      = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_WANTED_NAME        = 8'd1;
   localparam logic [CsrIdxW-1:0] CSR_WANTED_NAME_LENGTH = 8'd2;

   localparam logic [7:0]  NAME_CNT_MAX  = 8'hFF;
   localparam logic [11:0] VALUE_CNT_MAX = 12'hFFF;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  role;
      logic        pair_end;
      logic        name_matches;
      logic [7:0]  name_length;
      logic [11:0] value_length;
      logic        stopped;
      logic        found;
   } rsp_payload_type;

endpackage

/* rtl/core/bskv_if.sv */
interface bskv_req_if;
   logic                      valid;
   logic                      ready;
   bskv_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bskv_rsp_if;
   logic                      valid;
   logic                      ready;
   bskv_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/bskv_name_cmp.sv */
module bskv_name_cmp #(
   parameter int unsigned MAX_NAME_BYTES = 8
) (
   input  logic [7:0]  name_index,
   input  logic [7:0]  name_byte,
   input  logic [63:0] wanted_name,
   input  logic [3:0]  wanted_length,
   output logic [3:0]  wanted_length_sat,
   output logic        byte_hit
);
   import bskv_pkg::*;

   localparam logic [3:0] MaxLen = 4'(MAX_NAME_BYTES);

   logic [7:0] wanted_byte;

   // Clamp the wanted length to the supported name size
   assign wanted_length_sat = (wanted_length > MaxLen) ? MaxLen : wanted_length;

   // Pick the wanted byte at this name position; positions past the length never hit
   assign wanted_byte = wanted_name[{name_index[2:0], 3'b000} +: 8];
   assign byte_hit    = (name_index < {4'd0, wanted_length_sat})
                        && (wanted_byte == name_byte);

endmodule

/* rtl/core/boot_string_key_value_parser.sv */
// Boot-parameter string tokenizer. Feed one byte of the region per req beat,
// with last_byte on the final byte; every req beat yields exactly one rsp beat
// carrying the byte, its role and, on the byte that closes a NAME=value or
// NAME='value' pair, the saturated name and value lengths and a name match flag.
// The parse state is registered per accepted byte, and a new byte is accepted
// every clock while the result register can drain; the rsp beat appears in the
// cycle after its req beat is taken. The result register holds a waiting beat
// until rsp is ready and takes the next byte as it drains. After the last byte, all
// parse state returns to its reset value. There is no clearing pass after reset.
module boot_string_key_value_parser #(
   parameter int unsigned MAX_NAME_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   bskv_req_if.sink                        req_chan,
   bskv_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [bskv_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [63:0]                     csr_wr_data
);
   import bskv_pkg::*;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_NAME,
      PH_VSTART,
      PH_VALUE
   } phase_type;

   // Configuration registers
   logic        lookup_enable_ff;
   logic [63:0] wanted_name_ff;
   logic [3:0]  wanted_length_ff;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic        in_quotes_ff, in_quotes_in;
   logic        name_eq_ff, name_eq_in;
   logic [7:0]  name_cnt_ff, name_cnt_in;
   logic [11:0] value_cnt_ff, value_cnt_in;
   logic        stop_ff, stop_in;
   logic        found_ff, found_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic       req_take;
   logic [7:0] b;
   logic       last;
   logic       start_name;
   logic [7:0] name_base;
   logic [3:0] wl_sat;
   logic       byte_hit;
   logic [11:0] value_inc;
   logic       match;
   logic       finish;

   assign req_take = req_chan.valid && req_chan.ready;
   assign b        = req_chan.payload.byte_in;
   assign last     = req_chan.payload.last_byte;

   // Accept while the result register is empty or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // A name starting from the skip phase compares from position zero
   assign start_name = (phase_ff == PH_SKIP);
   assign name_base  = start_name ? 8'd0 : name_cnt_ff;

   bskv_name_cmp #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_name_cmp (
      .name_index        (name_base),
      .name_byte         (b),
      .wanted_name       (wanted_name_ff),
      .wanted_length     (wanted_length_ff),
      .wanted_length_sat (wl_sat),
      .byte_hit          (byte_hit)
   );

   assign value_inc = (value_cnt_ff == VALUE_CNT_MAX) ? value_cnt_ff
                                                      : value_cnt_ff + 12'd1;
   assign match     = name_eq_ff && (name_cnt_ff == {4'd0, wl_sat});

   // Work out the next parse state and the result for this beat
   always_comb begin
      logic [7:0] term;
      phase_in     = phase_ff;
      in_quotes_in = in_quotes_ff;
      name_eq_in   = name_eq_ff;
      name_cnt_in  = name_cnt_ff;
      value_cnt_in = value_cnt_ff;
      stop_in      = stop_ff;
      found_in     = found_ff;
      finish       = 1'b0;
      term         = in_quotes_ff ? QUOTE_CH : SPACE_CH;

      rsp_in              = '0;
      rsp_in.byte_out     = b;
      rsp_in.role         = ROLE_SKIP;

      if (stop_ff) begin
         rsp_in.role = ROLE_IGNORED;
      end else if (phase_ff == PH_SKIP || phase_ff == PH_NAME) begin
         if (b == NUL_CH) begin
            stop_in = 1'b1;
         end else if (b == EQUAL_CH) begin
            if (start_name) begin
               name_cnt_in = 8'd0;
               name_eq_in  = 1'b1;
            end
            phase_in = PH_VSTART;
         end else if (start_name && (b inside {SPACE_CH, [TAB_CH:CR_CH]})) begin
            rsp_in.role = ROLE_SKIP;
         end else begin
            // Name byte: compare and count from the proper base
            phase_in    = PH_NAME;
            name_eq_in  = (start_name || name_eq_ff) && byte_hit;
            name_cnt_in = (name_base == NAME_CNT_MAX) ? name_base : name_base + 8'd1;
            rsp_in.role = ROLE_NAME;
            if (last) begin
               stop_in = 1'b1;
            end
         end
      end else if (phase_ff == PH_VSTART && b == QUOTE_CH) begin
         in_quotes_in = 1'b1;
         phase_in     = PH_VALUE;
      end else begin
         // Value byte; an unquoted value opens here from the start phase
         if (phase_ff == PH_VSTART) begin
            in_quotes_in = 1'b0;
            term         = SPACE_CH;
         end
         phase_in = PH_VALUE;
         if (b == NUL_CH) begin
            finish  = 1'b1;
            stop_in = 1'b1;
         end else if (b == term) begin
            finish = 1'b1;
         end else begin
            value_cnt_in = value_inc;
            rsp_in.role  = ROLE_VALUE;
            finish       = last;
         end
      end

      // Close the pair and clear per-pair state
      if (finish) begin
         rsp_in.pair_end     = 1'b1;
         rsp_in.name_matches = match;
         rsp_in.name_length  = name_cnt_ff;
         rsp_in.value_length = value_cnt_in;
         if (lookup_enable_ff && match) begin
            found_in = 1'b1;
            stop_in  = 1'b1;
         end
         phase_in     = PH_SKIP;
         in_quotes_in = 1'b0;
         name_eq_in   = 1'b1;
         name_cnt_in  = 8'd0;
         value_cnt_in = 12'd0;
      end

      rsp_in.stopped = stop_in;
      rsp_in.found   = found_in;

      // Region end: drop all parse state back to its reset value
      if (last) begin
         phase_in     = PH_SKIP;
         in_quotes_in = 1'b0;
         name_eq_in   = 1'b1;
         name_cnt_in  = 8'd0;
         value_cnt_in = 12'd0;
         stop_in      = 1'b0;
         found_in     = 1'b0;
      end
   end

   // Hold state, configuration and the result register
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         lookup_enable_ff <= 1'b0;
         wanted_name_ff   <= 64'd0;
         wanted_length_ff <= 4'd1;
         phase_ff         <= PH_SKIP;
         in_quotes_ff     <= 1'b0;
         name_eq_ff       <= 1'b1;
         name_cnt_ff      <= 8'd0;
         value_cnt_ff     <= 12'd0;
         stop_ff          <= 1'b0;
         found_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOOKUP_ENABLE:      lookup_enable_ff <= csr_wr_data[0];
               CSR_WANTED_NAME:        wanted_name_ff   <= csr_wr_data;
               CSR_WANTED_NAME_LENGTH: wanted_length_ff <= csr_wr_data[3:0];
               default: ;
            endcase
         end
         if (req_take) begin
            phase_ff     <= phase_in;
            in_quotes_ff <= in_quotes_in;
            name_eq_ff   <= name_eq_in;
            name_cnt_ff  <= name_cnt_in;
            value_cnt_ff <= value_cnt_in;
            stop_ff      <= stop_in;
            found_ff     <= found_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   // A pair closes only on a delimiter or a value byte
   a_pair_end_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pair_end |->
         rsp_ff.role == ROLE_SKIP || rsp_ff.role == ROLE_VALUE)
      else $error("pair end reported on a name or ignored byte");

   // A completed lookup always stops the parse
   a_found_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.stopped)
      else $error("found without stopped");

   // A stalled result beat keeps its byte when a new byte cannot enter
   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_take)
      else $error("byte accepted over a stalled result");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule

/* tb/bskv_token_checker.sv */
// Watches the byte and result channels, predicts the tokenizer output for every
// accepted byte and compares each result beat against the oldest prediction.
module bskv_token_checker
   import bskv_pkg::*;
#(
   parameter int unsigned MAX_NAME_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   bskv_req_if                   req_chan,
   bskv_rsp_if                   rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CsrIdxW-1:0]    csr_index,
   input  logic [63:0]           csr_wr_data,
   output int unsigned           outstanding,
   output int unsigned           fail_count
);

   typedef enum logic [1:0] {
      SCAN_SKIP,
      SCAN_NAME,
      SCAN_VALUE_START,
      SCAN_VALUE
   } scan_state_type;

   // Mirrored registers
   logic        lookup_on;
   logic [63:0] want_name;
   logic [3:0]  want_len;

   // Tokenizer state
   scan_state_type scan;
   logic        quoted;
   logic        name_equal;
   logic [7:0]  name_len;
   logic [11:0] value_len;
   logic        halted;
   logic        found_seen;

   rsp_payload_type expected_tokens[$];
   int unsigned     mismatches = 0;

   assign fail_count = mismatches;

   function automatic void clear_pair();
      scan       = SCAN_SKIP;
      quoted     = 1'b0;
      name_equal = 1'b1;
      name_len   = '0;
      value_len  = '0;
   endfunction

   function automatic void compare_field(string label, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
         if (mismatches < 100)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   // Advance the tokenizer by one byte and return the result it should report
   function automatic rsp_payload_type predict_token(req_payload_type beat);
      rsp_payload_type res;
      logic [7:0]      ch;
      int unsigned     wl;
      logic            closing;
      res          = '0;
      ch           = beat.byte_in;
      res.byte_out = ch;
      res.role     = ROLE_SKIP;
      closing      = 1'b0;
      wl           = (want_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : want_len;

      if (halted) begin
         res.role = ROLE_IGNORED;
      end else if (scan == SCAN_SKIP || scan == SCAN_NAME) begin
         if (ch == NUL_CH) begin
            halted = 1'b1;
         end else if (ch == EQUAL_CH) begin
            if (scan == SCAN_SKIP) begin
               name_len   = '0;
               name_equal = 1'b1;
            end
            scan = SCAN_VALUE_START;
         end else if (!(scan == SCAN_SKIP &&
                        (ch == SPACE_CH || (ch >= TAB_CH && ch <= CR_CH)))) begin
            if (scan == SCAN_SKIP) begin
               name_len   = '0;
               name_equal = 1'b1;
            end
            scan = SCAN_NAME;
            // Compare against the wanted name only within its saturated length
            if (name_len < wl) begin
               if (want_name[8*name_len +: 8] != ch)
                  name_equal = 1'b0;
            end else begin
               name_equal = 1'b0;
            end
            if (name_len != NAME_CNT_MAX)
               name_len++;
            res.role = ROLE_NAME;
            // A region that ends inside a name leaves it malformed
            if (beat.last_byte)
               halted = 1'b1;
         end
      end else if (scan == SCAN_VALUE_START && ch == QUOTE_CH) begin
         quoted = 1'b1;
         scan   = SCAN_VALUE;
      end else begin
         if (scan == SCAN_VALUE_START)
            quoted = 1'b0;
         scan = SCAN_VALUE;
         if (ch == NUL_CH) begin
            closing = 1'b1;
            halted  = 1'b1;
         end else if (ch == (quoted ? QUOTE_CH : SPACE_CH)) begin
            closing = 1'b1;
         end else begin
            if (value_len != VALUE_CNT_MAX)
               value_len++;
            res.role = ROLE_VALUE;
            closing  = beat.last_byte;
         end
      end

      // Report the finished pair and stop on the first lookup hit
      if (closing) begin
         res.pair_end     = 1'b1;
         res.name_matches = name_equal && (name_len == wl);
         res.name_length  = name_len;
         res.value_length = value_len;
         if (lookup_on && res.name_matches) begin
            found_seen = 1'b1;
            halted     = 1'b1;
         end
         clear_pair();
      end

      res.stopped = halted;
      res.found   = found_seen;

      // The end of a region starts the parse over
      if (beat.last_byte) begin
         clear_pair();
         halted     = 1'b0;
         found_seen = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_pair();
         halted     = 1'b0;
         found_seen = 1'b0;
         lookup_on  = 1'b0;
         want_name  = '0;
         want_len   = 4'd1;
         expected_tokens.delete();
      end else begin
         // Check the result beat against the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tokens.size() == 0) begin
               if (mismatches < 100)
                  $display("%0t: result beat 0x%0h arrived with nothing expected, expected none",
                           $time, rsp_chan.payload);
               mismatches++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("byte_out", 12'(want.byte_out), 12'(rsp_chan.payload.byte_out));
               compare_field("role", 12'(want.role), 12'(rsp_chan.payload.role));
               compare_field("pair_end", 12'(want.pair_end), 12'(rsp_chan.payload.pair_end));
               compare_field("name_matches", 12'(want.name_matches),
                             12'(rsp_chan.payload.name_matches));
               compare_field("name_length", 12'(want.name_length),
                             12'(rsp_chan.payload.name_length));
               compare_field("value_length", want.value_length,
                             rsp_chan.payload.value_length);
               compare_field("stopped", 12'(want.stopped), 12'(rsp_chan.payload.stopped));
               compare_field("found", 12'(want.found), 12'(rsp_chan.payload.found));
            end
         end

         // Mirror register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LOOKUP_ENABLE:      lookup_on = csr_wr_data[0];
               CSR_WANTED_NAME:        want_name = csr_wr_data;
               CSR_WANTED_NAME_LENGTH: want_len  = csr_wr_data[3:0];
               default: ;
            endcase
         end

         if (req_chan.valid && req_chan.ready)
            expected_tokens.push_back(predict_token(req_chan.payload));
      end
      outstanding <= expected_tokens.size();
   end

endmodule

/* tb/boot_string_key_value_parser_tb.sv */
module boot_string_key_value_parser_tb;
   import bskv_pkg::*;

   localparam int unsigned CycleLimit = 1_000_000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [63:0]        csr_wr_data;

   bskv_req_if req_chan ();
   bskv_rsp_if rsp_chan ();

   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned cycle_count = 0;

   bit          idle_on;
   bit          hold_off_pending;
   logic [63:0] cfg_name;
   logic [3:0]  cfg_len;
   logic [7:0]  region_q[$];

   boot_string_key_value_parser #(
      .MAX_NAME_BYTES(8)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   bskv_token_checker #(
      .MAX_NAME_BYTES(8)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic void push_text(string s);
      for (int k = 0; k < s.len(); k++)
         region_q.push_back(s[k]);
   endfunction

   function automatic void push_blank();
      int k;
      k = $urandom_range(0, 5);
      region_q.push_back((k == 5) ? SPACE_CH : 8'(TAB_CH + k));
   endfunction

   // Add a name: the wanted one, a near miss, letters, or arbitrary bytes
   function automatic void push_name();
      int         wl;
      int         n;
      logic [7:0] b;
      wl = (cfg_len > 8) ? 8 : cfg_len;
      case ($urandom_range(0, 3))
         0: for (int k = 0; k < wl; k++)
               region_q.push_back(cfg_name[8*k +: 8]);
         1: begin
            n = $urandom_range(0, wl + 1);
            for (int k = 0; k < n; k++)
               region_q.push_back((k < wl) ? cfg_name[8*k +: 8] : 8'($urandom_range(97, 122)));
         end
         2: repeat ($urandom_range(1, 10))
               region_q.push_back(8'($urandom_range(97, 122)));
         default: repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(1, 255));
            if (b == EQUAL_CH)
               b = QUOTE_CH;
            region_q.push_back(b);
         end
      endcase
   endfunction

   // Offer every byte of the region, the final one flagged as last
   task automatic send_region();
      for (int k = 0; k < region_q.size(); k++) begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         req_chan.valid   <= 1'b1;
         req_chan.payload <= '{byte_in: region_q[k], last_byte: 1'(k == region_q.size() - 1)};
         do @(posedge clock); while (!req_chan.ready);
      end
      region_q.delete();
   endtask

   // Drop valid and drain every expected result
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      bit          look;
      logic [63:0] nm;
      logic [3:0]  ln;
      int          sent;
      int          pairs;
      logic        quoted_val;
      logic [7:0]  term;
      logic [7:0]  b;

      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wr_data      <= '0;
      idle_on          = 1'b1;
      hold_off_pending = 1'b0;
      cfg_name         = '0;
      cfg_len          = 4'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed regions under the reset register values
      push_text("\troot='a b'");
      send_region();
      region_q.push_back(EQUAL_CH);     // empty name, region ends inside the value
      region_q.push_back(8'hFF);
      send_region();
      push_text("ab");                  // region ends inside a name
      send_region();
      push_text("k=");                  // region ends at the equal sign
      send_region();
      push_text("k='");                 // region ends at the opening quote
      send_region();
      push_text("a=b");                 // NUL closes the value, the rest is ignored
      region_q.push_back(NUL_CH);
      push_text("c");
      send_region();
      wait_idle();

      // Saturate the name length in one pair
      idle_on = 1'b0;
      repeat (258) region_q.push_back(8'h6E);
      region_q.push_back(EQUAL_CH);
      repeat (3) region_q.push_back(8'h76);
      region_q.push_back(SPACE_CH);
      send_region();
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin look = 1'b0; nm = 64'h0000_0000_746F_6F72; ln = 4'd4; end  // "root"
            1: begin look = 1'b1; nm = 64'h0000_0000_746F_6F72; ln = 4'd4; end
            2, 5: begin
               look = 1'b1;
               for (int k = 0; k < 8; k++)
                  nm[8*k +: 8] = 8'($urandom_range(97, 122));
               ln = (p == 2) ? 4'd8 : 4'd15;
            end
            3: begin look = 1'b0; nm = 64'h0000_0000_0070_0069; ln = 4'd3; end  // NUL inside
            4: begin look = 1'b1; nm = {$urandom, $urandom}; ln = 4'd0; end
            6: begin look = 1'b0; nm = '1; ln = 4'd8; end
            default: begin look = 1'b1; nm = 64'h0000_0000_0000_7069; ln = 4'd2; end
         endcase

         // Program all three registers while idle
         cfg_name = nm;
         cfg_len  = ln;
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_LOOKUP_ENABLE;
         csr_wr_data <= 64'(look);
         @(posedge clock);
         csr_index   <= CSR_WANTED_NAME;
         csr_wr_data <= nm;
         @(posedge clock);
         csr_index   <= CSR_WANTED_NAME_LENGTH;
         csr_wr_data <= 64'(ln);
         @(posedge clock);
         csr_wr_en <= 1'b0;

         idle_on = (p != 7);
         if (p == 1)
            hold_off_pending = 1'b1;

         sent = 0;
         while (sent < 25) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise region
               repeat ($urandom_range(1, 12))
                  region_q.push_back(8'($urandom_range(0, 255)));
            end else begin
               pairs = $urandom_range(1, 4);
               for (int k = 0; k < pairs; k++) begin
                  repeat ($urandom_range(0, 2)) push_blank();
                  push_name();
                  region_q.push_back(EQUAL_CH);
                  quoted_val = 1'($urandom_range(0, 1));
                  term = quoted_val ? QUOTE_CH : SPACE_CH;
                  if (quoted_val)
                     region_q.push_back(QUOTE_CH);
                  repeat ($urandom_range(0, 6)) begin
                     case ($urandom_range(0, 39))
                        0: b = NUL_CH;
                        1, 2, 3, 4, 5, 6, 7, 8: begin
                           b = 8'($urandom_range(1, 255));
                           if (b == term)
                              b = EQUAL_CH;
                        end
                        default: b = 8'($urandom_range(97, 122));
                     endcase
                     region_q.push_back(b);
                  end
                  if (k < pairs - 1 || $urandom_range(0, 1) == 1)
                     region_q.push_back(term);
               end
               // Vary how the region ends, or break it
               case ($urandom_range(0, 7))
                  0: repeat ($urandom_range(1, 3)) push_blank();
                  1: begin
                     region_q.push_back(NUL_CH);
                     repeat ($urandom_range(0, 3))
                        region_q.push_back(8'($urandom_range(0, 255)));
                  end
                  2: push_name();
                  3: begin
                     push_name();
                     region_q.push_back(EQUAL_CH);
                  end
                  4: begin
                     push_name();
                     region_q.push_back(EQUAL_CH);
                     region_q.push_back(QUOTE_CH);
                  end
                  5: region_q[$urandom_range(0, region_q.size() - 1)] =
                        8'($urandom_range(0, 255));
                  default: ;
               endcase
            end
            sent += region_q.size();
            send_region();
         end
         wait_idle();
      end

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
